FILE: sv/rv64_pkg.sv
package rv64_pkg;

    localparam int REG_COUNT = 32;
    localparam int REG_AW    = 5;

    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_SUB  = 7'h20;

    localparam logic [0:0] ACT_EXEC    = 1'b0;
    localparam logic [0:0] ACT_PRELOAD = 1'b1;

    localparam logic [1:0] ST_EXEC    = 2'd0;
    localparam logic [1:0] ST_UNSUP   = 2'd1;
    localparam logic [1:0] ST_PRELOAD = 2'd2;

    typedef struct packed {
        logic [0:0]  action;
        logic [31:0] instruction;
        logic [63:0] pc;
        logic [7:0]  preload_index;
        logic [63:0] preload_data;
    } cmd_word_t;

    typedef struct packed {
        logic [63:0] next_pc;
        logic        branch_taken;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [63:0] reg_value;
        logic        store_done;
        logic [63:0] store_address;
        logic [63:0] store_value;
        logic [1:0]  status;
    } res_word_t;

endpackage

FILE: sv/rv64_subset_core_step_core.sv
// An accepted word is registered in s1_reg, then s2_reg, then res_reg on res.
// Throughput: one word per cycle while res_ready does not stall; register reads
// are forwarded from the two writes still in flight, and the data memory port
// serves one access a cycle. Reset clears the pipeline and the register file
// valid bits at once; a clearing pass then zeroes dmem with cmd_ready low.
module rv64_subset_core_step_core #(
    parameter int DMEM_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  rv64_pkg::cmd_word_t  cmd,
    output logic                 res_valid,
    input  logic                 res_ready,
    output rv64_pkg::res_word_t  res
);

    localparam int AW = $clog2(DMEM_DEPTH);

    logic [63:0] rf_mem [rv64_pkg::REG_COUNT];
    logic [63:0] dmem [DMEM_DEPTH];

    logic [rv64_pkg::REG_COUNT-1:0] rf_vld_reg;
    logic [63:0] rf_a_reg;
    logic [63:0] rf_b_reg;
    logic        rf_a_vld_reg;
    logic        rf_b_vld_reg;

    logic        clr_busy_reg;
    logic [AW-1:0] clr_idx_reg;

    logic                s1_valid_reg;
    rv64_pkg::cmd_word_t s1_reg;
    logic                s2_valid_reg;
    rv64_pkg::res_word_t s2_reg;
    logic                s2_load_reg;
    logic                res_valid_reg;
    rv64_pkg::res_word_t res_reg;
    rv64_pkg::res_word_t res_next;

    logic                  wb_valid_reg;
    logic [rv64_pkg::REG_AW-1:0] wb_idx_reg;
    logic [63:0]           wb_val_reg;

    logic [63:0] dm_rdata_reg;

    logic advance;
    logic accept;
    logic commit;
    logic [63:0] s2_wval;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic [63:0] imm_i;
    logic [63:0] imm_s;
    logic [63:0] imm_b;
    logic [63:0] opa;
    logic [63:0] opb;
    logic [63:0] opnd;
    logic [63:0] alu_val;
    logic [63:0] mem_addr;
    logic [63:0] pl_wide;
    logic        ok;
    logic        wr;
    logic        is_load;
    logic        is_store;
    logic        taken;
    logic        is_sub;
    rv64_pkg::res_word_t s2_next;

    logic          dm_we;
    logic [AW-1:0] dm_widx;
    logic [63:0]   dm_wdata;
    logic          dm_re;

    assign advance   = !res_valid_reg || res_ready;
    assign cmd_ready = !clr_busy_reg && (!s1_valid_reg || advance);
    assign accept    = cmd_valid && cmd_ready;
    assign s2_wval   = s2_load_reg ? dm_rdata_reg : s2_reg.reg_value;
    assign commit    = advance && s2_valid_reg && s2_reg.reg_written;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Operand forwarding: the item one stage ahead has not written yet, and the
    // write recorded last may have landed at the same edge as this item's register read.
    function automatic logic [63:0] fwd_operand(
        input logic [4:0]  idx,
        input logic        s2_hit,
        input logic [63:0] s2_val,
        input logic        wb_hit,
        input logic [63:0] wb_val,
        input logic        rf_vld,
        input logic [63:0] rf_val
    );
        logic [63:0] v;
        v = '0;
        if (s2_hit) begin
            v = s2_val;
        end else if (wb_hit) begin
            v = wb_val;
        end else if (rf_vld) begin
            v = rf_val;
        end
        if (idx == '0) begin
            v = '0;
        end
        return v;
    endfunction

    always_comb
    begin
        opc   = s1_reg.instruction[6:0];
        rd    = s1_reg.instruction[11:7];
        f3    = s1_reg.instruction[14:12];
        rs1   = s1_reg.instruction[19:15];
        rs2   = s1_reg.instruction[24:20];
        f7    = s1_reg.instruction[31:25];
        imm_i = {{52{s1_reg.instruction[31]}}, s1_reg.instruction[31:20]};
        imm_s = {{52{s1_reg.instruction[31]}}, f7, rd};
        imm_b = {{51{s1_reg.instruction[31]}}, s1_reg.instruction[31],
                 s1_reg.instruction[7], s1_reg.instruction[30:25],
                 s1_reg.instruction[11:8], 1'b0};

        opa = fwd_operand(rs1,
                          s2_valid_reg && s2_reg.reg_written && s2_reg.reg_index == rs1,
                          s2_wval, wb_valid_reg && wb_idx_reg == rs1, wb_val_reg,
                          rf_a_vld_reg, rf_a_reg);
        opb = fwd_operand(rs2,
                          s2_valid_reg && s2_reg.reg_written && s2_reg.reg_index == rs2,
                          s2_wval, wb_valid_reg && wb_idx_reg == rs2, wb_val_reg,
                          rf_b_vld_reg, rf_b_reg);

        ok       = 1'b1;
        wr       = 1'b0;
        is_load  = 1'b0;
        is_store = 1'b0;
        taken    = 1'b0;
        alu_val  = '0;
        is_sub   = (opc == rv64_pkg::OPC_OP) && (f3 == rv64_pkg::F3_ADD)
                   && (f7 == rv64_pkg::F7_SUB);
        opnd     = (opc == rv64_pkg::OPC_OP) ? opb : imm_i;
        mem_addr = opa + ((opc == rv64_pkg::OPC_STORE) ? imm_s : imm_i);

        unique case (opc)
            rv64_pkg::OPC_OP, rv64_pkg::OPC_OP_IMM:
            begin
                if (opc == rv64_pkg::OPC_OP && !is_sub && f7 != rv64_pkg::F7_BASE) begin
                    ok = 1'b0;
                end
                unique case (f3)
                    rv64_pkg::F3_ADD: alu_val = is_sub ? opa - opnd : opa + opnd;
                    rv64_pkg::F3_XOR: alu_val = opa ^ opnd;
                    rv64_pkg::F3_OR:  alu_val = opa | opnd;
                    rv64_pkg::F3_AND: alu_val = opa & opnd;
                    default:          ok = 1'b0;
                endcase
                wr = ok;
            end
            rv64_pkg::OPC_LOAD:
            begin
                is_load = 1'b1;
                wr      = 1'b1;
            end
            rv64_pkg::OPC_STORE:
            begin
                is_store = 1'b1;
            end
            rv64_pkg::OPC_BRANCH:
            begin
                unique case (f3)
                    rv64_pkg::F3_BEQ:  taken = (opa == opb);
                    rv64_pkg::F3_BNE:  taken = (opa != opb);
                    rv64_pkg::F3_BLT:  taken = ($signed(opa) < $signed(opb));
                    rv64_pkg::F3_BGE:  taken = !($signed(opa) < $signed(opb));
                    rv64_pkg::F3_BLTU: taken = (opa < opb);
                    rv64_pkg::F3_BGEU: taken = (opa >= opb);
                    default:           ok = 1'b0;
                endcase
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        if (rd == '0) begin
            wr = 1'b0;
        end

        s2_next               = '0;
        s2_next.next_pc       = s1_reg.pc + (taken ? imm_b : 64'd4);
        s2_next.branch_taken  = taken;
        s2_next.reg_written   = wr;
        s2_next.reg_index     = wr ? rd : '0;
        s2_next.reg_value     = (wr && !is_load) ? alu_val : '0;
        s2_next.store_done    = is_store;
        s2_next.store_address = is_store ? mem_addr : '0;
        s2_next.store_value   = is_store ? opb : '0;
        s2_next.status        = ok ? rv64_pkg::ST_EXEC : rv64_pkg::ST_UNSUP;

        if (s1_reg.action == rv64_pkg::ACT_PRELOAD) begin
            s2_next        = '0;
            s2_next.status = rv64_pkg::ST_PRELOAD;
            is_load        = 1'b0;
            is_store       = 1'b0;
            wr             = 1'b0;
        end
    end

    always_comb
    begin
        pl_wide  = 64'(s1_reg.preload_index);
        dm_we    = 1'b0;
        dm_widx  = mem_addr[AW+2:3];
        dm_wdata = opb;
        dm_re    = advance && s1_valid_reg && is_load;
        if (clr_busy_reg) begin
            dm_we    = 1'b1;
            dm_widx  = clr_idx_reg;
            dm_wdata = '0;
        end else if (advance && s1_valid_reg) begin
            if (s1_reg.action == rv64_pkg::ACT_PRELOAD) begin
                dm_we    = 1'b1;
                dm_widx  = pl_wide[AW-1:0];
                dm_wdata = s1_reg.preload_data;
            end else if (is_store) begin
                dm_we = 1'b1;
            end
        end
    end

    always_comb
    begin
        res_next           = s2_reg;
        res_next.reg_value = s2_wval;
    end

    always_ff @(posedge clk)
    begin
        if (dm_we) begin
            dmem[dm_widx] <= dm_wdata;
        end
        if (dm_re) begin
            dm_rdata_reg <= dmem[mem_addr[AW+2:3]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit) begin
            rf_mem[s2_reg.reg_index] <= s2_wval;
        end
        if (accept) begin
            rf_a_reg <= rf_mem[cmd.instruction[19:15]];
            rf_b_reg <= rf_mem[cmd.instruction[24:20]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_reg <= cmd;
        end
        if (advance && s1_valid_reg) begin
            s2_reg      <= s2_next;
            s2_load_reg <= is_load && wr;
        end
        if (advance && s2_valid_reg) begin
            res_reg <= res_next;
        end
        if (commit) begin
            wb_idx_reg <= s2_reg.reg_index;
            wb_val_reg <= s2_wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
            rf_vld_reg    <= '0;
            rf_a_vld_reg  <= 1'b0;
            rf_b_vld_reg  <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(DMEM_DEPTH - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cmd_ready) begin
                s1_valid_reg <= accept;
            end
            if (advance) begin
                s2_valid_reg  <= s1_valid_reg;
                res_valid_reg <= s2_valid_reg;
            end
            if (commit) begin
                wb_valid_reg                  <= 1'b1;
                rf_vld_reg[s2_reg.reg_index] <= 1'b1;
            end
            if (accept) begin
                rf_a_vld_reg <= rf_vld_reg[cmd.instruction[19:15]];
                rf_b_vld_reg <= rf_vld_reg[cmd.instruction[24:20]];
            end
        end
    end

endmodule
